// ===== rtl/vt4_pkg.sv =====
package vt4_pkg;

  // Payload widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned ELEMS   = 16;
  localparam int unsigned DIM     = 4;

  // Exact product and sum widths: four 32x32 products fit in 66 bits
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // Default fraction bits (Q16.16)
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Saturation limits
  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Item modes
  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_VEC4  = 2'd1,
    MODE_POINT = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

endpackage

// ===== rtl/vt4_if.sv =====
// Input channel: matrix loads and vectors to transform
interface vt4_in_if;
  logic                                 valid;
  logic                                 ready;
  vt4_pkg::mode_t                       mode;
  logic [vt4_pkg::INDEX_W-1:0]          elem_index;
  logic signed [vt4_pkg::DATA_W-1:0]    load_value;
  logic signed [vt4_pkg::DATA_W-1:0]    in_x;
  logic signed [vt4_pkg::DATA_W-1:0]    in_y;
  logic signed [vt4_pkg::DATA_W-1:0]    in_z;
  logic signed [vt4_pkg::DATA_W-1:0]    in_w;

  modport source (output valid, mode, elem_index, load_value, in_x, in_y, in_z, in_w,
                  input ready);
  modport sink (input valid, mode, elem_index, load_value, in_x, in_y, in_z, in_w,
                output ready);
endinterface

// Output channel: transformed vectors
interface vt4_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [vt4_pkg::DATA_W-1:0]    out_x;
  logic signed [vt4_pkg::DATA_W-1:0]    out_y;
  logic signed [vt4_pkg::DATA_W-1:0]    out_z;
  logic signed [vt4_pkg::DATA_W-1:0]    out_w;
  logic                                 overflow;

  modport source (output valid, out_x, out_y, out_z, out_w, overflow, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, overflow, output ready);
endinterface

// ===== rtl/vertex_transform_4x4.sv =====
// Each accepted transform passes stages 1, 2 and 3, then the output register, at
// one transaction per cycle unless result.ready stalls; 16 multipliers in stage 1,
// then two adder stages and a shift/saturate stage into the output register.
// A load is applied at its accept edge and seen by the very next transaction.
// Reset (rst, synchronous) empties the pipeline and restores the identity matrix.
module vertex_transform_4x4 #(
  parameter int unsigned FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  vt4_in_if.sink          vertex,
  vt4_out_if.source       result
);

  localparam int unsigned DATA_W = vt4_pkg::DATA_W;
  localparam int unsigned PROD_W = vt4_pkg::PROD_W;
  localparam int unsigned PAIR_W = vt4_pkg::PAIR_W;
  localparam int unsigned SUM_W  = vt4_pkg::SUM_W;
  localparam int unsigned DIM    = vt4_pkg::DIM;
  localparam int unsigned ELEMS  = vt4_pkg::ELEMS;
  localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  // Matrix store, column-major
  logic signed [DATA_W-1:0] m [ELEMS];

  // Pipeline registers
  logic                     v1, v2, v3;
  logic signed [PROD_W-1:0] p  [DIM][DIM];
  logic signed [PAIR_W-1:0] s  [DIM][2];
  logic signed [SUM_W-1:0]  t  [DIM];

  // Stage enables, back to front
  logic en1, en2, en3, en_out;
  logic accept, is_load, is_xform;

  // Operand vector with w replaced by one for points
  logic signed [DATA_W-1:0] vec [DIM];

  // Shift and saturate
  logic signed [SUM_W-1:0]  sh   [DIM];
  logic signed [DATA_W-1:0] sat  [DIM];
  logic [DIM-1:0]           ovf;

  assign en_out = !result.valid || result.ready;
  assign en3    = !v3 || en_out;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;

  assign vertex.ready = en1;
  assign accept   = vertex.valid && vertex.ready;
  assign is_load  = vertex.mode == vt4_pkg::MODE_LOAD;
  assign is_xform = vertex.mode == vt4_pkg::MODE_VEC4 || vertex.mode == vt4_pkg::MODE_POINT;

  always_comb begin
    vec[0] = vertex.in_x;
    vec[1] = vertex.in_y;
    vec[2] = vertex.in_z;
    vec[3] = (vertex.mode == vt4_pkg::MODE_POINT) ? ONE : vertex.in_w;
  end

  // Matrix load, identity on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ELEMS; i++) begin
        m[i] <= (i % (DIM + 1) == 0) ? ONE : '0;
      end
    end else if (accept && is_load) begin
      m[vertex.elem_index] <= vertex.load_value;
    end
  end

  // Stage 1: products m[j+4k] * v[k]
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept && is_xform;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int j = 0; j < DIM; j++) begin
        for (int k = 0; k < DIM; k++) begin
          p[j][k] <= m[j + DIM * k] * vec[k];
        end
      end
    end
  end

  // Stage 2: pair sums
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int j = 0; j < DIM; j++) begin
        s[j][0] <= PAIR_W'(p[j][0]) + PAIR_W'(p[j][1]);
        s[j][1] <= PAIR_W'(p[j][2]) + PAIR_W'(p[j][3]);
      end
    end
  end

  // Stage 3: full sums, exact
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int j = 0; j < DIM; j++) begin
        t[j] <= SUM_W'(s[j][0]) + SUM_W'(s[j][1]);
      end
    end
  end

  // Floor shift, then saturate to 32 bits
  always_comb begin
    for (int j = 0; j < DIM; j++) begin
      sh[j]  = t[j] >>> FRAC_BITS;
      ovf[j] = !((&sh[j][SUM_W-1:DATA_W-1]) || !(|sh[j][SUM_W-1:DATA_W-1]));
      if (ovf[j]) begin
        sat[j] = sh[j][SUM_W-1] ? vt4_pkg::SAT_MIN : vt4_pkg::SAT_MAX;
      end else begin
        sat[j] = sh[j][DATA_W-1:0];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en_out) begin
      result.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      result.out_x    <= sat[0];
      result.out_y    <= sat[1];
      result.out_z    <= sat[2];
      result.out_w    <= sat[3];
      result.overflow <= |ovf;
    end
  end

`ifndef SYNTH
  // A load lands in the addressed element
  a_load_written: assert property (@(posedge clk) disable iff (rst)
    accept && is_load |=> m[$past(vertex.elem_index)] == $past(vertex.load_value))
    else $error("matrix load not applied");

  // A transform transaction enters stage 1
  a_xform_enters: assert property (@(posedge clk) disable iff (rst)
    accept && is_xform |=> v1)
    else $error("transform transaction lost at stage 1");

  // A finished sum moves into the output register
  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    v3 && en_out |=> result.valid)
    else $error("result lost at output stage");

  // Overflow only with a saturated component
  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.overflow |->
      (result.out_x == vt4_pkg::SAT_MAX || result.out_x == vt4_pkg::SAT_MIN ||
       result.out_y == vt4_pkg::SAT_MAX || result.out_y == vt4_pkg::SAT_MIN ||
       result.out_z == vt4_pkg::SAT_MAX || result.out_z == vt4_pkg::SAT_MIN ||
       result.out_w == vt4_pkg::SAT_MAX || result.out_w == vt4_pkg::SAT_MIN))
    else $error("overflow flagged without saturation");
`endif

endmodule
